// File: src/bca_pkg.sv
package bca_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEPS        = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam int POS_BITS  = 32;
    localparam int OFS_BITS  = POS_BITS + 1;
    localparam int PRE_SHIFT = 24;
    localparam int VEC_BITS  = OFS_BITS + PRE_SHIFT + 3;
    localparam int OUT_BITS  = 16;

    // Offset stage, setup stage, one stage per rotation, output stage.
    localparam int NUM_STAGES = STEPS + 3;

    localparam int AT_SHIFT = 32 - ANGLE_BITS;
    localparam int SH_DOWN  = (ANGLE_BITS > OUT_BITS) ? ANGLE_BITS - OUT_BITS : 1;
    localparam int SH_UP    = (ANGLE_BITS < OUT_BITS) ? OUT_BITS - ANGLE_BITS : 0;

    typedef logic signed [OFS_BITS-1:0]   t_ofs;
    typedef logic signed [VEC_BITS-1:0]   t_vec;
    typedef logic        [ANGLE_BITS-1:0] t_ang;
    typedef logic        [OUT_BITS-1:0]   t_out;

    // Arctangent of 2^-i, one full turn equal to 2^32.
    localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam t_ang HALF_TURN = t_ang'(1) << (ANGLE_BITS - 1);

    localparam logic [32:0]         AT_RND  = 33'd1 << (AT_SHIFT - 1);
    localparam logic [ANGLE_BITS:0] OUT_RND = (ANGLE_BITS + 1)'(1) << (SH_DOWN - 1);

    function automatic t_ang step_angle(input int idx);
        logic [32:0] t;
        t = {1'b0, ATAN_TURN32[idx]} + AT_RND;
        return t_ang'(t >> AT_SHIFT);
    endfunction

    function automatic t_out to_out_angle(input t_ang z);
        logic [ANGLE_BITS:0] t;
        t = {1'b0, z} + OUT_RND;
        if (ANGLE_BITS > OUT_BITS) begin
            return t_out'(t >> SH_DOWN);
        end else begin
            return t_out'(t_out'(z) << SH_UP);
        end
    endfunction

endpackage

// File: src/bearing_correction_angle.sv
// An accepted input beat passes the offset, setup, rotation and output stages before its result appears.
// Throughput: one beat per cycle unless the output is stalled; the pipeline holds one item per register stage.
// A downstream stall backs up only the stages that are full, so bubbles are squeezed out.
// Reset is synchronous and active low; it clears the stage valid bits only.
module bearing_correction_angle (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_rover_x,
    input  logic [31:0] i_rover_y,
    input  logic [15:0] i_rover_heading,
    input  logic [31:0] i_goal_x,
    input  logic [31:0] i_goal_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_turn_angle
);

    localparam int NS = bca_pkg::NUM_STAGES;
    localparam int LS = NS - 1;

    logic [NS-1:0]  r_v;
    logic [NS-1:0]  w_en;
    bca_pkg::t_vec  r_x     [1:LS-1];
    bca_pkg::t_vec  r_y     [1:LS-1];
    bca_pkg::t_ang  r_z     [1:LS-1];
    logic [15:0]    r_hd    [LS];
    logic           r_zero  [LS];
    bca_pkg::t_ofs  r_dx;
    bca_pkg::t_ofs  r_dy;
    bca_pkg::t_out  r_turn;

    bca_pkg::t_ofs  n_dx;
    bca_pkg::t_ofs  n_dy;
    bca_pkg::t_vec  n_px;
    bca_pkg::t_vec  n_py;
    bca_pkg::t_out  n_bearing;

    assign w_en[LS] = !r_v[LS] || !i_stall;
    for (genvar k = 0; k < LS; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end

    assign o_stall      = !w_en[0];
    assign o_valid      = r_v[LS];
    assign o_turn_angle = r_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // The goal offset is formed one bit wider than the positions, so it is exact.
    assign n_dx = {i_goal_x[31], i_goal_x} - {i_rover_x[31], i_rover_x};
    assign n_dy = {i_goal_y[31], i_goal_y} - {i_rover_y[31], i_rover_y};

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_hd[0]   <= i_rover_heading;
            r_zero[0] <= (n_dx == '0) && (n_dy == '0);
        end
    end

    assign n_px = bca_pkg::t_vec'($signed({r_dx, {bca_pkg::PRE_SHIFT{1'b0}}}));
    assign n_py = bca_pkg::t_vec'($signed({r_dy, {bca_pkg::PRE_SHIFT{1'b0}}}));

    // A goal behind the vehicle is turned through a half turn so x starts non-negative.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_x[1]    <= r_dx[bca_pkg::OFS_BITS-1] ? -n_px : n_px;
            r_y[1]    <= r_dx[bca_pkg::OFS_BITS-1] ? -n_py : n_py;
            r_z[1]    <= r_dx[bca_pkg::OFS_BITS-1] ? bca_pkg::HALF_TURN : '0;
            r_hd[1]   <= r_hd[0];
            r_zero[1] <= r_zero[0];
        end
    end

    for (genvar j = 0; j < bca_pkg::STEPS; j++) begin : g_step
        localparam int K = j + 2;
        localparam bca_pkg::t_ang ANG = bca_pkg::step_angle(j);

        bca_pkg::t_vec xs;
        bca_pkg::t_vec ys;

        assign xs = r_x[K-1] >>> j;
        assign ys = r_y[K-1] >>> j;

        always_ff @(posedge i_clk) begin
            if (w_en[K]) begin
                if (r_y[K-1][bca_pkg::VEC_BITS-1]) begin
                    r_x[K] <= r_x[K-1] - ys;
                    r_y[K] <= r_y[K-1] + xs;
                    r_z[K] <= r_z[K-1] - ANG;
                end else begin
                    r_x[K] <= r_x[K-1] + ys;
                    r_y[K] <= r_y[K-1] - xs;
                    r_z[K] <= r_z[K-1] + ANG;
                end
                r_hd[K]   <= r_hd[K-1];
                r_zero[K] <= r_zero[K-1];
            end
        end
    end

    assign n_bearing = r_zero[LS-1] ? '0 : bca_pkg::to_out_angle(r_z[LS-1]);

    // Two's-complement wrap of the difference gives the shortest turn.
    always_ff @(posedge i_clk) begin
        if (w_en[LS]) begin
            r_turn <= n_bearing - r_hd[LS-1];
        end
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output stage can move");

    a_output_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && i_rst_n && (!o_valid || !i_stall)) |=> (o_valid == $past(r_v[LS-1])))
        else $error("output valid did not follow the last rotation stage");

    a_x_nonnegative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LS-1] |-> !r_x[LS-1][bca_pkg::VEC_BITS-1])
        else $error("rotation x went negative");

    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && r_zero[1]) |-> ((r_x[1] == '0) && (r_y[1] == '0)))
        else $error("zero offset flag set on a nonzero vector");
`endif

endmodule

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROTATIONS      = bca_pkg::CORDIC_STEPS;
    localparam int ANG_BITS       = bca_pkg::ANGLE_BITS;
    localparam int PIPE_DEPTH     = bca_pkg::NUM_STAGES;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_WAIT       = 18;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] POS_MIN = 32'h8000_0000;
    localparam logic [15:0] HEAD_MAX = 16'h7FFF;
    localparam logic [15:0] HEAD_MIN = 16'h8000;

    localparam logic [31:0] ARCTAN_TURN [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct {
        int          beat;
        logic [15:0] turn;
    } t_turn_expect;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        i_stall         = 1'b0;
    logic [31:0] i_rover_x       = '0;
    logic [31:0] i_rover_y       = '0;
    logic [15:0] i_rover_heading = '0;
    logic [31:0] i_goal_x        = '0;
    logic [31:0] i_goal_y        = '0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_turn_angle;

    t_turn_expect pending_turns[$];
    int           beat_count     = 0;
    int           mismatch_count = 0;
    int           hold_left      = 0;
    bit           steady         = 1'b0;

    bearing_correction_angle u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rover_x       (i_rover_x),
        .i_rover_y       (i_rover_y),
        .i_rover_heading (i_rover_heading),
        .i_goal_x        (i_goal_x),
        .i_goal_y        (i_goal_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_turn_angle    (o_turn_angle)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] predict_turn(input logic [31:0] rx, input logic [31:0] ry,
                                                 input logic [15:0] hd, input logic [31:0] gx,
                                                 input logic [31:0] gy);
        longint      dx;
        longint      dy;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [63:0] z;
        logic [63:0] amask;
        logic [63:0] step;
        int          sh;
        logic [15:0] bearing;
        dx = longint'($signed(gx)) - longint'($signed(rx));
        dy = longint'($signed(gy)) - longint'($signed(ry));
        amask = (64'd1 << ANG_BITS) - 64'd1;
        z = '0;
        if (dx == 0 && dy == 0) begin
            bearing = '0;
        end else begin
            x = dx <<< 24;
            y = dy <<< 24;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 64'd1 << (ANG_BITS - 1);
            end
            for (int i = 0; i < ROTATIONS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                step = (64'(ARCTAN_TURN[i]) + (64'd1 << (31 - ANG_BITS))) >> (32 - ANG_BITS);
                if (y < 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - step;
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + step;
                end
                z = z & amask;
            end
            sh = ANG_BITS - 16;
            if (sh > 0) begin
                z = (z + (64'd1 << (sh - 1))) >> sh;
            end else if (sh < 0) begin
                z = z << (-sh);
            end
            bearing = z[15:0];
        end
        return bearing - hd;
    endfunction

    function automatic int draw_wait();
        if (steady) begin
            return 0;
        end
        if ($urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(input string what, input int beat, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch (%s) at beat %0d: got %0d, expected %0d", what, beat,
                 $signed(got), $signed(want));
        mismatch_count++;
    endtask

    task automatic send_pose(input logic [31:0] rx, input logic [31:0] ry,
                             input logic [15:0] hd, input logic [31:0] gx,
                             input logic [31:0] gy);
        int           gap;
        t_turn_expect entry;
        gap = draw_wait();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_rover_x       = rx;
        i_rover_y       = ry;
        i_rover_heading = hd;
        i_goal_x        = gx;
        i_goal_y        = gy;
        i_valid         = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        entry.beat = beat_count;
        entry.turn = predict_turn(rx, ry, hd, gx, gy);
        pending_turns.push_back(entry);
        beat_count++;
    endtask

    task automatic shuffle_pace(input int n);
        if (n % 50 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
        end
    endtask

    always @(posedge i_clk) begin : check_turns
        t_turn_expect want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_turns.size() == 0) begin
                report_mismatch("unexpected beat", -1, o_turn_angle, '0);
            end else begin
                want = pending_turns.pop_front();
                if (o_turn_angle !== want.turn) begin
                    report_mismatch("turn_angle", want.beat, o_turn_angle, want.turn);
                end
            end
            hold_left = draw_wait();
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall = 1'b0;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    task automatic test_zero_offset();
        send_pose('0, '0, '0, '0, '0);
        send_pose(POS_MAX, POS_MIN, HEAD_MAX, POS_MAX, POS_MIN);
        send_pose(POS_MIN, POS_MAX, HEAD_MIN, POS_MIN, POS_MAX);
        send_pose(32'h1234_5678, 32'hDEAD_BEEF, 16'h0001, 32'h1234_5678, 32'hDEAD_BEEF);
    endtask

    task automatic test_axes();
        send_pose('0, '0, '0, 32'd1, '0);
        send_pose('0, '0, '0, -32'sd1, '0);
        send_pose('0, '0, '0, '0, 32'd1);
        send_pose('0, '0, '0, '0, -32'sd1);
        send_pose('0, '0, 16'h1000, 32'd5, 32'd5);
        send_pose('0, '0, 16'hF000, -32'sd5, 32'd5);
        send_pose('0, '0, HEAD_MAX, -32'sd5, -32'sd5);
        send_pose('0, '0, HEAD_MIN, 32'd5, -32'sd5);
    endtask

    task automatic test_offset_extremes();
        send_pose(POS_MIN, POS_MIN, '0, POS_MAX, POS_MAX);
        send_pose(POS_MAX, POS_MAX, HEAD_MAX, POS_MIN, POS_MIN);
        send_pose(POS_MIN, POS_MAX, HEAD_MIN, POS_MAX, POS_MIN);
        send_pose(POS_MAX, '0, '0, POS_MIN, '0);
        send_pose('0, POS_MIN, 16'h4000, '0, POS_MAX);
        send_pose(POS_MAX, POS_MIN, 16'hFFFF, POS_MIN, POS_MAX);
    endtask

    // A goal straight behind or a heading exactly opposite must come out as minus pi.
    task automatic test_opposite_facing();
        send_pose('0, '0, HEAD_MIN, 32'd100, '0);
        send_pose('0, '0, '0, -32'sd100, '0);
        send_pose('0, '0, 16'hC000, '0, 32'd7);
        send_pose(32'd3, 32'd9, 16'h4000, 32'd3, 32'd2);
    endtask

    task automatic test_random_poses(input int count);
        for (int n = 0; n < count; n++) begin
            shuffle_pace(n);
            send_pose($urandom, $urandom, 16'($urandom), $urandom, $urandom);
        end
    endtask

    task automatic test_random_nearby(input int count);
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] dx;
        logic [31:0] dy;
        for (int n = 0; n < count; n++) begin
            shuffle_pace(n);
            rx = $urandom;
            ry = $urandom;
            dx = $signed($urandom) >>> $urandom_range(0, 31);
            dy = $signed($urandom) >>> $urandom_range(0, 31);
            send_pose(rx, ry, 16'($urandom), rx + dx, ry + dy);
        end
    endtask

    task automatic test_random_aligned(input int count);
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] d;
        logic [31:0] dx;
        logic [31:0] dy;
        for (int n = 0; n < count; n++) begin
            shuffle_pace(n);
            rx = $urandom;
            ry = $urandom;
            d  = $signed($urandom) >>> $urandom_range(0, 31);
            case ($urandom_range(0, 3))
                0: begin
                    dx = d;
                    dy = '0;
                end
                1: begin
                    dx = '0;
                    dy = d;
                end
                2: begin
                    dx = d;
                    dy = d;
                end
                default: begin
                    dx = d;
                    dy = -d;
                end
            endcase
            send_pose(rx, ry, 16'($urandom), rx + dx, ry + dy);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_offset();
        test_axes();
        steady = 1'b1;
        test_offset_extremes();
        steady = 1'b0;
        test_opposite_facing();
        test_random_poses(600);
        test_random_nearby(900);
        test_random_aligned(350);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_turns.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
